>>> hw/rtl/touch_event_classifier_top_defines.svh
// Assertion macros shared by the touch event classifier RTL.
// Depends on nothing; expects clk and rst_n in the including module.
`ifndef TOUCH_EVENT_CLASSIFIER_TOP_DEFINES_SVH
`define TOUCH_EVENT_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tec_pkg.sv
// Types and constants of the touch event classifier.
// Used by tec_core and touch_event_classifier_top; no dependencies.
package tec_pkg;

  typedef enum logic [1:0] {
    EV_UP     = 2'd0,
    EV_DOWN   = 2'd1,
    EV_MOTION = 2'd2,
    EV_LONG   = 2'd3
  } ev_kind_t;

  localparam logic OP_EMPTY  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SWAP_XY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR   = 3'd4;

  localparam int SCALE_W  = 10;
  localparam int LONG_W   = 16;
  localparam int THR_W    = 12;
  localparam int PRESS_W  = 12;
  localparam int OUT_W    = 16;

  localparam logic [SCALE_W-1:0] SCALE_RST      = 10'd100;
  localparam logic [LONG_W-1:0]  LONG_PRESS_RST = 16'd900;
  localparam logic [THR_W-1:0]   MOVE_THR_RST   = 12'd5;

  typedef struct packed {
    logic               swap_xy;
    logic [SCALE_W-1:0] x_scale;
    logic [SCALE_W-1:0] y_scale;
    logic [LONG_W-1:0]  long_press;
    logic [THR_W-1:0]   move_thr;
  } cfg_t;

  typedef struct packed {
    logic     emit;
    ev_kind_t kind;
  } ev_ctl_t;

endpackage

>>> hw/rtl/tec_core.sv
// Event classification and tracking state (last event, last sample, hold counter).
// Depends on tec_pkg.
module tec_core #(
  parameter int COORD_BITS = 12,
  parameter int HOLD_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  tec_pkg::cfg_t                 cfg,
  input  logic                          op,
  input  logic [tec_pkg::PRESS_W-1:0]   pressure,
  input  logic [COORD_BITS-1:0]         x,
  input  logic [COORD_BITS-1:0]         y,
  output tec_pkg::ev_ctl_t              ev,
  output logic [COORD_BITS-1:0]         ev_x,
  output logic [COORD_BITS-1:0]         ev_y
);
  import tec_pkg::*;

  localparam int DIFF_W = ((COORD_BITS > THR_W) ? COORD_BITS : THR_W) + 1;

  ev_kind_t              last_event_r, last_event_nxt;
  logic [COORD_BITS-1:0] last_x_r, last_x_nxt;
  logic [COORD_BITS-1:0] last_y_r, last_y_nxt;
  logic [HOLD_BITS-1:0]  hold_r, hold_nxt;

  logic [HOLD_BITS-1:0]  hold_inc;
  logic [COORD_BITS-1:0] sx, sy;
  logic [DIFF_W-1:0]     dx, dy;
  logic                  moved;
  logic                  long_due;

  assign hold_inc = (&hold_r) ? hold_r : hold_r + 1'b1;
  assign sx       = cfg.swap_xy ? y : x;
  assign sy       = cfg.swap_xy ? x : y;
  assign dx       = (last_x_r > sx) ? DIFF_W'(last_x_r - sx) : DIFF_W'(sx - last_x_r);
  assign dy       = (last_y_r > sy) ? DIFF_W'(last_y_r - sy) : DIFF_W'(sy - last_y_r);
  assign moved    = (dx > DIFF_W'(cfg.move_thr)) || (dy > DIFF_W'(cfg.move_thr));
  assign long_due = (last_event_r != EV_UP) && (32'(hold_inc) > 32'(cfg.long_press));

  always_comb begin
    last_event_nxt = last_event_r;
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    hold_nxt       = hold_inc;
    ev.emit        = 1'b0;
    ev.kind        = EV_UP;
    ev_x           = sx;
    ev_y           = sy;
    if (op == OP_EMPTY) begin
      ev_x = last_x_r;
      ev_y = last_y_r;
      if (long_due) begin
        hold_nxt       = '0;
        last_event_nxt = EV_LONG;
        ev.emit        = 1'b1;
        ev.kind        = EV_LONG;
      end
    end else begin
      last_x_nxt = sx;
      last_y_nxt = sy;
      if (pressure == '0) begin
        last_event_nxt = EV_UP;
        ev.emit        = 1'b1;
        ev.kind        = EV_UP;
      end else begin
        hold_nxt = '0;
        priority if (last_event_r == EV_UP) begin
          last_event_nxt = EV_DOWN;
          ev.emit        = 1'b1;
          ev.kind        = EV_DOWN;
        end else if (moved) begin
          last_event_nxt = EV_MOTION;
          ev.emit        = 1'b1;
          ev.kind        = EV_MOTION;
        end else begin
          ev.emit = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_event_r <= EV_UP;
      last_x_r     <= '0;
      last_y_r     <= '0;
      hold_r       <= '0;
    end else if (step) begin
      last_event_r <= last_event_nxt;
      last_x_r     <= last_x_nxt;
      last_y_r     <= last_y_nxt;
      hold_r       <= hold_nxt;
    end
  end

endmodule

>>> hw/rtl/touch_event_classifier_top.sv
// Touch event classifier top: input word register, classifier, percent scaling.
// Depends on tec_pkg, tec_core and touch_event_classifier_top_defines.svh.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  in      | in_valid / in_ready | in_operation, in_pressure, in_x_in, in_y_in
//  out     | out_valid/out_ready | out_event_kind, out_x_out, out_y_out
//  cfg     | cfg_we              | cfg_index, cfg_wdata
//
// One word per cycle unless the output stalls; a taken word passes through the
// input register, coordinate times percent and reciprocal multiply for /100.
// Words without a result drop out after the classifier stage.
// Each stage advances when its successor is empty or moving, so a stalled
// output still lets earlier stages fill. Synchronous reset clears control
// state and the classifier state; configuration resets to its defaults.
`include "touch_event_classifier_top_defines.svh"

module touch_event_classifier_top #(
  parameter int COORD_BITS = 12,
  parameter int HOLD_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [tec_pkg::PRESS_W-1:0]      in_pressure,
  input  logic [COORD_BITS-1:0]            in_x_in,
  input  logic [COORD_BITS-1:0]            in_y_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_event_kind,
  output logic [tec_pkg::OUT_W-1:0]        out_x_out,
  output logic [tec_pkg::OUT_W-1:0]        out_y_out,
  input  logic                             cfg_we,
  input  logic [tec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tec_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tec_pkg::*;

  localparam int PROD_W  = COORD_BITS + SCALE_W;
  localparam int SHIFT   = PROD_W + 7;
  localparam int RECIP_W = SHIFT - 6;
  localparam int QUO_W   = PROD_W - 6;
  localparam longint unsigned RECIP_VAL = ((64'd1 << SHIFT) + 64'd99) / 64'd100;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  cfg_t cfg_r;

  logic                  v1_r, v2_r, v3_r;
  logic                  adv1, adv2, core_step;
  logic                  s1_op_r;
  logic [PRESS_W-1:0]    s1_press_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;

  ev_ctl_t               ev;
  logic [COORD_BITS-1:0] ev_x, ev_y;

  ev_kind_t              s2_kind_r, s3_kind_r;
  logic [PROD_W-1:0]     s2_prod_x_r, s2_prod_y_r;
  logic [PROD_W+RECIP_W-1:0] full_x, full_y;
  logic [QUO_W-1:0]      quo_x, quo_y;
  logic [OUT_W-1:0]      sat_x, sat_y;
  logic [OUT_W-1:0]      s3_x_r, s3_y_r;

  assign adv2      = !v3_r || out_ready;
  assign adv1      = !v2_r || adv2;
  assign in_ready  = !v1_r || adv1;
  assign core_step = v1_r && adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swap_xy    <= 1'b0;
      cfg_r.x_scale    <= SCALE_RST;
      cfg_r.y_scale    <= SCALE_RST;
      cfg_r.long_press <= LONG_PRESS_RST;
      cfg_r.move_thr   <= MOVE_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SWAP_XY:    cfg_r.swap_xy    <= cfg_wdata[0];
        REG_X_SCALE:    cfg_r.x_scale    <= cfg_wdata[SCALE_W-1:0];
        REG_Y_SCALE:    cfg_r.y_scale    <= cfg_wdata[SCALE_W-1:0];
        REG_LONG_PRESS: cfg_r.long_press <= cfg_wdata[LONG_W-1:0];
        REG_MOVE_THR:   cfg_r.move_thr   <= cfg_wdata[THR_W-1:0];
        default:        cfg_r            <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_ready) v1_r <= in_valid;
      if (adv1)     v2_r <= core_step && ev.emit;
      if (adv2)     v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r    <= in_operation;
      s1_press_r <= in_pressure;
      s1_x_r     <= in_x_in;
      s1_y_r     <= in_y_in;
    end
    if (adv1) begin
      s2_kind_r   <= ev.kind;
      s2_prod_x_r <= PROD_W'(ev_x) * PROD_W'(cfg_r.x_scale);
      s2_prod_y_r <= PROD_W'(ev_y) * PROD_W'(cfg_r.y_scale);
    end
    if (adv2) begin
      s3_kind_r <= s2_kind_r;
      s3_x_r    <= sat_x;
      s3_y_r    <= sat_y;
    end
  end

  tec_core #(
    .COORD_BITS(COORD_BITS),
    .HOLD_BITS (HOLD_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (core_step),
    .cfg     (cfg_r),
    .op      (s1_op_r),
    .pressure(s1_press_r),
    .x       (s1_x_r),
    .y       (s1_y_r),
    .ev      (ev),
    .ev_x    (ev_x),
    .ev_y    (ev_y)
  );

  assign full_x = (PROD_W+RECIP_W)'(s2_prod_x_r) * (PROD_W+RECIP_W)'(RECIP);
  assign full_y = (PROD_W+RECIP_W)'(s2_prod_y_r) * (PROD_W+RECIP_W)'(RECIP);
  assign quo_x  = full_x[SHIFT +: QUO_W];
  assign quo_y  = full_y[SHIFT +: QUO_W];
  assign sat_x  = (32'(quo_x) > 32'hFFFF) ? {OUT_W{1'b1}} : OUT_W'(quo_x);
  assign sat_y  = (32'(quo_y) > 32'hFFFF) ? {OUT_W{1'b1}} : OUT_W'(quo_y);

  assign out_valid      = v3_r;
  assign out_event_kind = s3_kind_r;
  assign out_x_out      = s3_x_r;
  assign out_y_out      = s3_y_r;

  `TEC_ASSERT_NEXT(a_out_from_s2, adv2, v3_r == $past(v2_r), "output stage skipped a word")
  `TEC_ASSERT_NEXT(a_s1_hold, v1_r && !adv1, v1_r && $stable(s1_x_r), "stalled input word lost")
  `TEC_ASSERT_NEXT(a_in_taken, in_valid && in_ready, v1_r, "accepted word not registered")
  `TEC_ASSERT_NOW(a_s2_needs_room, v2_r && !adv1, v3_r && !out_ready, "classifier stalled with room")

endmodule
